// ===== rtl/ffra_pkg.sv =====
package ffra_pkg;

  // Default depth of the region table.
  localparam int unsigned MAX_REGIONS = 64;

  // Field widths.
  localparam int unsigned AddrW   = 64;
  localparam int unsigned TypeW   = 32;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned StatusW = 2;

  // Boot map type code for usable memory.
  localparam logic [TypeW-1:0] TypeUsable = 32'd1;

  // Operation codes.
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_ALLOC = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOFIT = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_KERNEL_BEGIN = 1'b0,
    CFG_KERNEL_END   = 1'b1
  } cfg_idx_e;

  // Source of a table write.
  typedef enum logic [1:0] {
    WR_WHOLE = 2'd0,
    WR_LOW   = 2'd1,
    WR_HIGH  = 2'd2,
    WR_UPD   = 2'd3
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    end_ld;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    scan_en;
    logic    res_ld;
    status_e res_st;
    logic    res_hit;
    logic    out_ld;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic whole;
    logic low;
    logic high;
    logic hit;
    logic miss;
  } sts_t;

endpackage

// ===== rtl/ffra_dp.sv =====
module ffra_dp #(
  parameter int unsigned MaxRegions = ffra_pkg::MAX_REGIONS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ffra_pkg::AddrW-1:0]   cfg_data_i,
  input  logic [ffra_pkg::AddrW-1:0]   region_base_i,
  input  logic [ffra_pkg::AddrW-1:0]   region_length_i,
  input  logic [ffra_pkg::TypeW-1:0]   region_type_i,
  input  logic [ffra_pkg::SizeW-1:0]   alloc_size_i,
  input  ffra_pkg::cmd_t               cmd_i,
  output ffra_pkg::sts_t               sts_o,
  output logic [ffra_pkg::StatusW-1:0] status_o,
  output logic [ffra_pkg::AddrW-1:0]   alloc_address_o
);

  localparam int unsigned IW = $clog2(MaxRegions);
  localparam int unsigned CW = $clog2(MaxRegions + 1);
  localparam int unsigned AW = ffra_pkg::AddrW;

  // Configuration registers.
  logic [AW-1:0] kbeg_q, kend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbeg_q <= '0;
      kend_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ffra_pkg::CFG_KERNEL_BEGIN) begin
        kbeg_q <= cfg_data_i;
      end else begin
        kend_q <= cfg_data_i;
      end
    end
  end

  // Captured input beat.
  logic [AW-1:0] base_q, len_q, end_q, end_d;
  logic          usable_q;
  logic [AW-1:0] want_q;
  logic [AW:0]   sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      base_q   <= region_base_i;
      len_q    <= region_length_i;
      usable_q <= (region_type_i == ffra_pkg::TypeUsable);
      want_q   <= {{(AW - ffra_pkg::SizeW){1'b0}}, alloc_size_i};
    end
    if (cmd_i.end_ld) begin
      end_q <= end_d;
    end
  end

  // Region end, clipped at the top of the address space.
  assign sum   = {1'b0, base_q} + {1'b0, len_q};
  assign end_d = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];

  // Entry count.
  logic [CW-1:0] count_q, count_d;
  logic [CW:0]   need_sum;
  logic [1:0]    need;

  // Placement of the loaded region against the kernel span.
  logic ld_whole, ld_low, ld_high, ld_full;

  assign ld_whole = (kend_q <= base_q) || (end_q <= kbeg_q);
  assign ld_low   = base_q < kbeg_q;
  assign ld_high  = kend_q < end_q;

  assign need     = {1'b0, ld_low} + {1'b0, ld_high};
  assign need_sum = {1'b0, count_q} + (CW + 1)'(need);

  assign ld_full  = ld_whole ? (count_q >= CW'(MaxRegions))
                             : (need_sum > (CW + 1)'(MaxRegions));

  // Scan read pipeline: one entry issued per cycle.
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic          rd_en;
  logic [AW-1:0] rd_start_q, rd_size_q;
  logic          rd_usable_q;
  logic          scan_hit, scan_miss;

  always_comb begin
    scan_idx_d = '0;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    rd_en      = 1'b0;
    if (cmd_i.scan_en) begin
      scan_idx_d = scan_idx_q;
      if (scan_idx_q < count_q) begin
        rd_en      = 1'b1;
        rd_vld_d   = 1'b1;
        rd_idx_d   = scan_idx_q[IW-1:0];
        scan_idx_d = scan_idx_q + CW'(1);
      end
    end
  end

  assign scan_hit  = rd_vld_q && rd_usable_q && (rd_size_q >= want_q);
  assign scan_miss = !rd_vld_q && (scan_idx_q == count_q);

  // Status bundle for the controller.
  assign sts_o = '{full: ld_full, whole: ld_whole, low: ld_low, high: ld_high,
                   hit: scan_hit, miss: scan_miss};

  // Write data selection.
  logic [AW-1:0] wr_start, wr_size;
  logic          wr_usable;
  logic [IW-1:0] wr_addr;

  always_comb begin
    wr_addr   = count_q[IW-1:0];
    wr_usable = usable_q;
    unique case (cmd_i.wr_sel)
      ffra_pkg::WR_WHOLE: begin
        wr_start = base_q;
        wr_size  = end_q - base_q;
      end
      ffra_pkg::WR_LOW: begin
        wr_start = base_q;
        wr_size  = kbeg_q - base_q;
      end
      ffra_pkg::WR_HIGH: begin
        wr_start = kend_q;
        wr_size  = end_q - kend_q;
      end
      ffra_pkg::WR_UPD: begin
        wr_start  = rd_start_q + want_q;
        wr_size   = rd_size_q - want_q;
        wr_usable = rd_usable_q;
        wr_addr   = rd_idx_q;
      end
      default: begin
        wr_start = base_q;
        wr_size  = end_q - base_q;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.wr_en && (cmd_i.wr_sel != ffra_pkg::WR_UPD)) begin
      count_d = count_q + CW'(1);
    end
  end

  // Region table memory.
  logic [AW-1:0] start_mem [MaxRegions];
  logic [AW-1:0] size_mem  [MaxRegions];
  logic          usable_mem[MaxRegions];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      start_mem[wr_addr]  <= wr_start;
      size_mem[wr_addr]   <= wr_size;
      usable_mem[wr_addr] <= wr_usable;
    end
    if (rd_en) begin
      rd_start_q  <= start_mem[rd_idx_d];
      rd_size_q   <= size_mem[rd_idx_d];
      rd_usable_q <= usable_mem[rd_idx_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
    end
  end

  // Pending result and output register.
  logic [ffra_pkg::StatusW-1:0] res_status_q, out_status_q;
  logic [AW-1:0]                res_addr_q, out_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      res_status_q <= cmd_i.res_st;
      res_addr_q   <= cmd_i.res_hit ? rd_start_q : '0;
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign status_o        = out_status_q;
  assign alloc_address_o = out_addr_q;

`ifndef SYNTH
  // The table never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxRegions))
    else $error("region count exceeds table depth");

  // A load write only happens while a free row remains.
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && (cmd_i.wr_sel != ffra_pkg::WR_UPD)) |-> (count_q < CW'(MaxRegions)))
    else $error("load write into a full table");

  // Each load write adds exactly one entry.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && (cmd_i.wr_sel != ffra_pkg::WR_UPD)) |=>
      (count_q == $past(count_q) + CW'(1)))
    else $error("region count did not advance on a load write");

  // An allocation update only targets an entry that was just read.
  a_upd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && (cmd_i.wr_sel == ffra_pkg::WR_UPD)) |-> rd_vld_q)
    else $error("allocation update without a read entry");
`endif

endmodule

// ===== rtl/ffra_ctrl.sv =====
module ffra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           func_i,
  input  logic           out_stall_i,
  input  ffra_pkg::sts_t sts_i,
  output ffra_pkg::cmd_t cmd_o,
  output logic           in_stall_o,
  output logic           out_valid_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LCALC = 6'b000010,
    S_LDEC  = 6'b000100,
    S_LHIGH = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Sequencer for one item at a time.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.wr_sel  = ffra_pkg::WR_WHOLE;
    cmd_o.res_st  = ffra_pkg::ST_OK;
    out_valid_d   = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (func_i == ffra_pkg::FUNC_ALLOC) ? S_SCAN : S_LCALC;
        end
      end
      S_LCALC: begin
        cmd_o.end_ld = 1'b1;
        state_d      = S_LDEC;
      end
      S_LDEC: begin
        cmd_o.res_ld = 1'b1;
        state_d      = S_DONE;
        if (sts_i.full) begin
          cmd_o.res_st = ffra_pkg::ST_FULL;
        end else if (sts_i.whole) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ffra_pkg::WR_WHOLE;
        end else if (sts_i.low) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ffra_pkg::WR_LOW;
          if (sts_i.high) begin
            state_d = S_LHIGH;
          end
        end else if (sts_i.high) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ffra_pkg::WR_HIGH;
        end
      end
      S_LHIGH: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ffra_pkg::WR_HIGH;
        state_d      = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.hit) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = ffra_pkg::WR_UPD;
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_hit = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.miss) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res_st = ffra_pkg::ST_NOFIT;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // The output register is only overwritten when its beat is gone or leaving.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (!out_valid_q || !out_stall_i))
    else $error("output beat overwritten while stalled");

  // Every finished item leaves a valid output beat behind.
  a_out_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |=> out_valid_q)
    else $error("output beat not raised after a result");

  // A table write never coincides with taking a new item.
  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !cmd_o.wr_en)
    else $error("table write while accepting an item");
`endif

endmodule

// ===== rtl/first_fit_region_allocator_top.sv =====
// Region table with a first-fit allocator.
// Input channel: in_valid_i / in_stall_o carry one item per beat. func_i low
// loads a boot map region (split around the kernel span), func_i high
// requests alloc_size_i bytes. Output channel: out_valid_o / out_stall_i
// carry one result beat per item (status_o, alloc_address_o).
// Configuration: cfg_we_i writes cfg_data_i into kernel_begin (index 0) or
// kernel_end (index 1); write only while the block is idle.
// Sequence: a load passes capture, end calculation and decision states, plus
// a second write state when it is split into two entries, then the output
// step. An allocation reads the table one entry per cycle through a
// registered memory port; it stops at the first fit or after the last entry.
// One item is worked on at a time; the next item is taken the cycle after its
// predecessor's result enters the output register, even if that beat is
// still stalled. A stalled result holds and blocks only the next result.
// Reset clears the kernel span to zero, empties the table and drops any
// pending output beat. Table contents are not cleared; only rows below the
// entry count are ever read.
module first_fit_region_allocator_top #(
  parameter int unsigned MaxRegions = ffra_pkg::MAX_REGIONS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ffra_pkg::AddrW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [ffra_pkg::AddrW-1:0]   region_base_i,
  input  logic [ffra_pkg::AddrW-1:0]   region_length_i,
  input  logic [ffra_pkg::TypeW-1:0]   region_type_i,
  input  logic [ffra_pkg::SizeW-1:0]   alloc_size_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ffra_pkg::StatusW-1:0] status_o,
  output logic [ffra_pkg::AddrW-1:0]   alloc_address_o
);

  ffra_pkg::cmd_t cmd;
  ffra_pkg::sts_t sts;

  // Sequencer.
  ffra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Region table and arithmetic.
  ffra_dp #(
    .MaxRegions (MaxRegions)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .region_base_i   (region_base_i),
    .region_length_i (region_length_i),
    .region_type_i   (region_type_i),
    .alloc_size_i    (alloc_size_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;

  // One request beat as the sender drives it.
  typedef struct {
    ffra_pkg::func_e            func;
    logic [ffra_pkg::AddrW-1:0] base;
    logic [ffra_pkg::AddrW-1:0] length;
    logic [ffra_pkg::TypeW-1:0] rtype;
    logic [ffra_pkg::SizeW-1:0] size;
  } request_t;

  // One result beat as the receiver sees it.
  typedef struct {
    ffra_pkg::status_e          status;
    logic [ffra_pkg::AddrW-1:0] addr;
  } outcome_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // A row of the directed table: either a register write or a request.
  typedef struct {
    row_kind_e                  kind;
    ffra_pkg::cfg_idx_e         idx;
    logic [ffra_pkg::AddrW-1:0] value;
    request_t                   req;
    bit                         typed;
    outcome_t                   want;
  } row_t;

  typedef enum int {
    RX_FLOW,
    RX_RANDOM,
    RX_HOLD
  } rx_mode_e;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic                         cfg_idx = 1'b0;
  logic [ffra_pkg::AddrW-1:0]   cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         func = 1'b0;
  logic [ffra_pkg::AddrW-1:0]   region_base = '0;
  logic [ffra_pkg::AddrW-1:0]   region_length = '0;
  logic [ffra_pkg::TypeW-1:0]   region_type = '0;
  logic [ffra_pkg::SizeW-1:0]   alloc_size = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ffra_pkg::StatusW-1:0] status;
  logic [ffra_pkg::AddrW-1:0]   alloc_address;

  first_fit_region_allocator_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (func),
    .region_base_i   (region_base),
    .region_length_i (region_length),
    .region_type_i   (region_type),
    .alloc_size_i    (alloc_size),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .alloc_address_o (alloc_address)
  );

  // Free-running clock, period 4.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Shadow copy of the kernel span and the region table.
  logic [ffra_pkg::AddrW-1:0] span_begin = '0;
  logic [ffra_pkg::AddrW-1:0] span_end = '0;
  logic [ffra_pkg::AddrW-1:0] map_start [ffra_pkg::MAX_REGIONS];
  logic [ffra_pkg::AddrW-1:0] map_size [ffra_pkg::MAX_REGIONS];
  logic                       map_usable [ffra_pkg::MAX_REGIONS];
  int unsigned                map_count = 0;

  outcome_t pending_outcomes[$];
  int       mismatches = 0;
  int       burst_left = 0;

  function automatic void store_region(logic [ffra_pkg::AddrW-1:0] start,
                                       logic [ffra_pkg::AddrW-1:0] size,
                                       logic usable);
    map_start[map_count]  = start;
    map_size[map_count]   = size;
    map_usable[map_count] = usable;
    map_count++;
  endfunction

  // Applies one request to the shadow table and returns the result it gives.
  function automatic outcome_t apply_request(request_t r);
    outcome_t                   res;
    logic [ffra_pkg::AddrW:0]   sum;
    logic [ffra_pkg::AddrW-1:0] last;
    logic                       usable;
    logic                       lo;
    logic                       hi;
    res.status = ffra_pkg::ST_OK;
    res.addr   = '0;
    if (r.func == ffra_pkg::FUNC_LOAD) begin
      // The region end is clipped at the top of the address space.
      sum    = {1'b0, r.base} + {1'b0, r.length};
      last   = sum[ffra_pkg::AddrW] ? '1 : sum[ffra_pkg::AddrW-1:0];
      usable = (r.rtype == ffra_pkg::TypeUsable);
      if (span_end <= r.base || last <= span_begin) begin
        if (map_count >= ffra_pkg::MAX_REGIONS) begin
          res.status = ffra_pkg::ST_FULL;
        end else begin
          store_region(r.base, last - r.base, usable);
        end
      end else begin
        // Keep only the parts below and above the kernel span.
        lo = (r.base < span_begin);
        hi = (span_end < last);
        if (map_count + lo + hi > ffra_pkg::MAX_REGIONS) begin
          res.status = ffra_pkg::ST_FULL;
        end else begin
          if (lo) store_region(r.base, span_begin - r.base, usable);
          if (hi) store_region(span_end, last - span_end, usable);
        end
      end
    end else begin
      // First fit: hand out the start, then bump it and shrink the entry.
      res.status = ffra_pkg::ST_NOFIT;
      for (int i = 0; i < map_count; i++) begin
        if (map_usable[i] && map_size[i] >= ffra_pkg::AddrW'(r.size)) begin
          res.status   = ffra_pkg::ST_OK;
          res.addr     = map_start[i];
          map_start[i] = map_start[i] + ffra_pkg::AddrW'(r.size);
          map_size[i]  = map_size[i] - ffra_pkg::AddrW'(r.size);
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic row_t item_row(ffra_pkg::func_e f, logic [ffra_pkg::AddrW-1:0] base,
                                    logic [ffra_pkg::AddrW-1:0] length,
                                    logic [ffra_pkg::TypeW-1:0] rtype,
                                    logic [ffra_pkg::SizeW-1:0] size);
    row_t r;
    r.kind        = ROW_ITEM;
    r.idx         = ffra_pkg::CFG_KERNEL_BEGIN;
    r.value       = '0;
    r.req.func    = f;
    r.req.base    = base;
    r.req.length  = length;
    r.req.rtype   = rtype;
    r.req.size    = size;
    r.typed       = 1'b0;
    r.want.status = ffra_pkg::ST_OK;
    r.want.addr   = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(ffra_pkg::cfg_idx_e idx,
                                   logic [ffra_pkg::AddrW-1:0] value);
    row_t r;
    r       = item_row(ffra_pkg::FUNC_LOAD, '0, '0, '0, '0);
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic row_t with_result(row_t r, ffra_pkg::status_e s,
                                       logic [ffra_pkg::AddrW-1:0] a);
    r.typed       = 1'b1;
    r.want.status = s;
    r.want.addr   = a;
    return r;
  endfunction

  // Random request aimed around the current kernel span.
  function automatic request_t random_request();
    request_t r;
    r.func = ($urandom_range(0, 3) == 0) ? ffra_pkg::FUNC_LOAD : ffra_pkg::FUNC_ALLOC;
    case ($urandom_range(0, 3))
      0: r.base = {$urandom, $urandom};
      1: r.base = span_begin - $urandom_range(0, 32'h0010_0000);
      2: r.base = span_end - $urandom_range(0, 32'h0000_8000);
      default: r.base = ffra_pkg::AddrW'($urandom_range(0, 32'h1000_0000));
    endcase
    case ($urandom_range(0, 5))
      0: r.length = {$urandom, $urandom};
      1: r.length = '0;
      default: r.length = ffra_pkg::AddrW'($urandom_range(1, 32'h0020_0000));
    endcase
    r.rtype = ($urandom_range(0, 4) == 0) ? ffra_pkg::TypeW'($urandom)
                                          : ffra_pkg::TypeUsable;
    case ($urandom_range(0, 5))
      0: r.size = $urandom;
      1: r.size = '0;
      default: r.size = $urandom_range(1, 32'h4000);
    endcase
    return r;
  endfunction

  // Sends one request beat, in bursts with random gaps, and records its result.
  task automatic offer(request_t r, bit typed, outcome_t want);
    int       gap;
    outcome_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    func          <= r.func;
    region_base   <= r.base;
    region_length <= r.length;
    region_type   <= r.rtype;
    alloc_size    <= r.size;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_request(r);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  // Stops offering and waits until every expected result beat has come.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(ffra_pkg::cfg_idx_e idx, logic [ffra_pkg::AddrW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffra_pkg::CFG_KERNEL_BEGIN) span_begin = value;
    else span_end = value;
    @(posedge clk);
  endtask

  // Receiver: checks each result beat and chooses the stall for the next cycle.
  int       results_seen = 0;
  int       hold_left = 0;
  bit       held_once = 1'b0;
  rx_mode_e rx_mode = RX_FLOW;
  int       rx_left = 0;

  always @(posedge clk) begin
    outcome_t want;
    if (out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (alloc_address !== want.addr)
          report_mismatch($sformatf("address %h, expected %h", alloc_address, want.addr));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held_once && results_seen >= 150) begin
      // One long hold-off so the block fills up and stalls its input.
      held_once = 1'b1;
      hold_left = 300;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 6) : $urandom_range(1, 30);
      end
      rx_left--;
      case (rx_mode)
        RX_FLOW:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
        default:   out_stall <= 1'b1;
      endcase
    end
  end

  // Stimulus: directed table, then random phases over several kernel spans.
  initial begin
    row_t                       plan[$];
    outcome_t                   no_outcome;
    logic [ffra_pkg::AddrW-1:0] kb;
    logic [ffra_pkg::AddrW-1:0] ke;
    no_outcome.status = ffra_pkg::ST_OK;
    no_outcome.addr   = '0;

    // Kernel span is zero after reset, so every region is stored whole.
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'h0),
                               ffra_pkg::ST_NOFIT, '0));
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_LOAD, 64'h1000, 64'h1000,
                                        ffra_pkg::TypeUsable, '0),
                               ffra_pkg::ST_OK, '0));
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'h100),
                               ffra_pkg::ST_OK, 64'h1000));
    // A zero-size request returns the start and leaves the entry alone.
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'h0),
                               ffra_pkg::ST_OK, 64'h1100));
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'hFFFF_FFFF),
                               ffra_pkg::ST_NOFIT, '0));
    // Region running past the top of memory.
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_LOAD, 64'hFFFF_FFFF_FFFF_F000, '1,
                                        ffra_pkg::TypeUsable, '0),
                               ffra_pkg::ST_OK, '0));
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_LOAD, '0, '1, 32'hFFFF_FFFF, '0),
                               ffra_pkg::ST_OK, '0));
    // Zero-length region.
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_LOAD, '0, '0,
                                        ffra_pkg::TypeUsable, '0),
                               ffra_pkg::ST_OK, '0));
    plan.push_back(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'hF00));
    plan.push_back(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'h1));
    // Ordinary kernel span: split, inside, and both neighbors.
    plan.push_back(cfg_row(ffra_pkg::CFG_KERNEL_BEGIN, 64'h1_0000));
    plan.push_back(cfg_row(ffra_pkg::CFG_KERNEL_END, 64'h2_0000));
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_LOAD, 64'h8000, 64'h2_0000,
                                        ffra_pkg::TypeUsable, '0),
                               ffra_pkg::ST_OK, '0));
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_LOAD, 64'h1_2000, 64'h1000,
                                        ffra_pkg::TypeUsable, '0),
                               ffra_pkg::ST_OK, '0));
    plan.push_back(item_row(ffra_pkg::FUNC_LOAD, 64'h2_0000, 64'h100,
                            ffra_pkg::TypeUsable, '0));
    plan.push_back(item_row(ffra_pkg::FUNC_LOAD, 64'h8000, 64'h8000,
                            ffra_pkg::TypeUsable, '0));
    plan.push_back(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'h8000));
    // Kernel begin above kernel end.
    plan.push_back(cfg_row(ffra_pkg::CFG_KERNEL_BEGIN, 64'h3_0000));
    plan.push_back(cfg_row(ffra_pkg::CFG_KERNEL_END, 64'h2_0000));
    plan.push_back(item_row(ffra_pkg::FUNC_LOAD, 64'h1_0000, 64'h3_0000,
                            ffra_pkg::TypeUsable, '0));
    plan.push_back(item_row(ffra_pkg::FUNC_LOAD, 64'h2_5000, 64'h100, 32'h2, '0));
    plan.push_back(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'h2_0000));
    // Kernel span covering all of memory.
    plan.push_back(cfg_row(ffra_pkg::CFG_KERNEL_BEGIN, '0));
    plan.push_back(cfg_row(ffra_pkg::CFG_KERNEL_END, '1));
    plan.push_back(with_result(item_row(ffra_pkg::FUNC_LOAD, 64'h5000, 64'h1000,
                                        ffra_pkg::TypeUsable, '0),
                               ffra_pkg::ST_OK, '0));
    plan.push_back(item_row(ffra_pkg::FUNC_LOAD, '1, '0, ffra_pkg::TypeUsable, '0));
    plan.push_back(item_row(ffra_pkg::FUNC_ALLOC, '0, '0, '0, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(ffra_pkg::CFG_KERNEL_BEGIN, '1));
    plan.push_back(item_row(ffra_pkg::FUNC_LOAD, 64'hFFFF_FFFF_0000_0000, '1,
                            ffra_pkg::TypeUsable, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        drain_results();
        write_register(plan[k].idx, plan[k].value);
      end else begin
        offer(plan[k].req, plan[k].typed, plan[k].want);
      end
    end

    for (int p = 0; p < 5; p++) begin
      drain_results();
      case (p)
        0: begin
          kb = 64'h4000_0000;
          ke = 64'h4800_0000;
        end
        1: begin
          kb = {$urandom, $urandom};
          ke = kb + $urandom_range(32'h1000, 32'h0010_0000);
        end
        2: begin
          kb = '1;
          ke = '0;
        end
        3: begin
          kb = '0;
          ke = '0;
        end
        default: begin
          kb = {$urandom, $urandom};
          ke = {$urandom, $urandom};
        end
      endcase
      write_register(ffra_pkg::CFG_KERNEL_BEGIN, kb);
      write_register(ffra_pkg::CFG_KERNEL_END, ke);
      repeat (100) offer(random_request(), 1'b0, no_outcome);
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ffra_pkg.sv
rtl/ffra_dp.sv
rtl/ffra_ctrl.sv
rtl/first_fit_region_allocator_top.sv
tb/testbench.sv
